>>> design/vsd_pkg.sv
// Shared types and constants for the varint stream decoder.
// No dependencies; used by vsd_step and varint_stream_decoder.
package vsd_pkg;

    typedef enum logic [1:0] {
        FMT_SIGNED   = 2'd0,
        FMT_UNSIGNED = 2'd1,
        FMT_MOD4     = 2'd2
    } format_t;

    localparam format_t FORMAT_RESET = FMT_UNSIGNED;

    localparam logic [7:0] LOW6_MASK    = 8'b0011_1111;
    localparam logic [7:0] LOW7_MASK    = 8'b0111_1111;
    localparam logic [7:0] CONT_BIT     = 8'b1000_0000;
    localparam logic [7:0] SGN_CONT_BIT = 8'b0100_0000;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  idx;
        logic        neg;
    } dec_state_t;

    // One step's outcome: next state plus a possible result.
    typedef struct packed {
        dec_state_t  state;
        logic        done;
        logic [31:0] value;
        logic [2:0]  count;
    } step_result_t;

endpackage

>>> design/vsd_step.sv
// Combinational decode of one stream byte against the current state.
// Depends on vsd_pkg for the format codes and state structs.
module vsd_step (
    input  vsd_pkg::format_t     fmt,
    input  vsd_pkg::dec_state_t  cur,
    input  logic [7:0]           data_byte,
    output vsd_pkg::step_result_t res
);

    logic [31:0] grp7;
    logic [31:0] add;
    logic [31:0] acc_or;
    logic        more;
    logic        neg_n;
    logic [31:0] value;

    assign grp7 = {24'd0, data_byte & vsd_pkg::LOW7_MASK};

    always_comb begin
        add   = 32'd0;
        more  = 1'b0;
        neg_n = cur.neg;
        case (fmt)
            vsd_pkg::FMT_SIGNED: begin
                case (cur.idx)
                    3'd0: begin
                        add   = {24'd0, data_byte & vsd_pkg::LOW6_MASK};
                        neg_n = data_byte[7];
                        more  = (data_byte & vsd_pkg::SGN_CONT_BIT) != 8'd0;
                    end
                    3'd1: begin
                        add  = grp7 << 6;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    3'd2: begin
                        add  = grp7 << 13;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    3'd3: begin
                        add  = grp7 << 20;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    default: begin
                        add = {data_byte[4:0], 27'd0};
                    end
                endcase
            end
            vsd_pkg::FMT_MOD4: begin
                case (cur.idx)
                    3'd0: begin
                        add  = grp7;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    3'd1: begin
                        add  = grp7 << 7;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    3'd2: begin
                        add  = grp7 << 14;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    default: begin
                        add = {3'd0, data_byte, 21'd0};
                    end
                endcase
            end
            default: begin
                // unsigned, and the unused code decodes the same way
                case (cur.idx)
                    3'd0: begin
                        add  = grp7;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    3'd1: begin
                        add  = grp7 << 7;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    3'd2: begin
                        add  = grp7 << 14;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    3'd3: begin
                        add  = grp7 << 21;
                        more = (data_byte & vsd_pkg::CONT_BIT) != 8'd0;
                    end
                    default: begin
                        add = {data_byte[3:0], 28'd0};
                    end
                endcase
            end
        endcase
    end

    assign acc_or = cur.acc | add;
    assign value  = (fmt == vsd_pkg::FMT_SIGNED && neg_n) ? (32'd0 - acc_or) : acc_or;

    always_comb begin
        res.done  = !more;
        res.value = value;
        res.count = cur.idx + 3'd1;
        if (more) begin
            res.state.acc = acc_or;
            res.state.idx = cur.idx + 3'd1;
            res.state.neg = neg_n;
        end else begin
            // value complete: start fresh
            res.state.acc = 32'd0;
            res.state.idx = 3'd0;
            res.state.neg = 1'b0;
        end
    end

endmodule

>>> design/varint_stream_decoder.sv
// Top level of the varint stream decoder: state, format register, result register.
// Depends on vsd_pkg and vsd_step.
//
// Usage:
//   s_valid/s_ready/s_data_byte carry the encoded byte stream, one byte per
//   request. m_valid/m_ready/m_value/m_byte_count carry one decoded value per
//   request, emitted on the byte that ends it. cfg_valid/cfg_ready/cfg_data
//   write the format register (0 signed sign-magnitude, 1 unsigned,
//   2 four-byte modified); a write also drops any partial value.
//   Throughput: one byte per cycle unless stalled. Each byte is decoded by a
//   single layer of shift/OR logic plus a 32-bit negate feeding the result
//   register; a final byte's result appears on m_ the cycle after it is accepted.
//   The result register is the only buffer: s_ready stays high while it is
//   empty or being drained, and drops while a result waits on a stalled
//   receiver or a format write is offered. Bytes that end no value pass
//   without touching the output side except through that stall.
//   Reset (aresetn low, synchronous) selects format 1, clears the partial
//   value and empties the result register. cfg_ready is always high.
module varint_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [2:0]  m_byte_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    vsd_pkg::format_t     format_reg;
    vsd_pkg::dec_state_t  state_reg;
    vsd_pkg::step_result_t step;
    logic                 out_valid_reg;
    logic [31:0]          out_value_reg;
    logic [2:0]           out_count_reg;
    logic                 s_fire;
    logic                 cfg_fire;

    vsd_step u_step (
        .fmt       (format_reg),
        .cur       (state_reg),
        .data_byte (s_data_byte),
        .res       (step)
    );

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    // hold bytes while a format write is offered
    assign s_ready   = (!out_valid_reg || m_ready) && !cfg_valid;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg    <= vsd_pkg::FORMAT_RESET;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_fire) begin
                format_reg <= vsd_pkg::format_t'(cfg_data);
                state_reg  <= '0;
            end else if (s_fire) begin
                state_reg <= step.state;
            end
            if (s_fire && !cfg_fire) begin
                out_valid_reg <= step.done;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: load only with a finished value
    always_ff @(posedge aclk) begin
        if (s_fire && step.done) begin
            out_value_reg <= step.value;
            out_count_reg <= step.count;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_value      = out_value_reg;
    assign m_byte_count = out_count_reg;

endmodule
